[hdl/dor_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dor_pkg
// shared widths and word types for the disk overlap resolver
// ----------------------------------------------------------------------------
package dor_pkg;

    localparam int COORD_W   = 24;  // signed coordinate width
    localparam int FRAC_BITS = 8;   // fraction bits of coordinates and radii
    localparam int RADIUS_W  = 20;  // unsigned radius width
    localparam int MASS_W    = 16;  // unsigned mass width

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_a_x;
        logic signed [COORD_W-1:0] pos_a_y;
        logic signed [COORD_W-1:0] pos_b_x;
        logic signed [COORD_W-1:0] pos_b_y;
        logic [RADIUS_W-1:0]       radius_a;
        logic [RADIUS_W-1:0]       radius_b;
        logic [MASS_W-1:0]         mass_a;
        logic [MASS_W-1:0]         mass_b;
        logic                      fixed_a;
        logic                      fixed_b;
    } dor_in_t;

    typedef struct packed {
        logic                      hit;
        logic signed [COORD_W-1:0] move_a_x;
        logic signed [COORD_W-1:0] move_a_y;
        logic signed [COORD_W-1:0] move_b_x;
        logic signed [COORD_W-1:0] move_b_y;
    } dor_out_t;

endpackage

[hdl/disk_overlap_resolver.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// disk_overlap_resolver
// pushes two overlapping disks apart, split by mass ratio
// ----------------------------------------------------------------------------
// One disk pair is taken whenever start is high; busy is always low, so a new
// word may enter in every cycle and results leave at one per cycle. The
// result word shows on result for exactly one cycle with done high, after its
// pair has passed the input, delta, squares and root seed registers, the
// bit-serial square root (one root bit per stage), the registers forming
// the scaled numerator and divisor and the divider seed, the restoring
// division (one quotient bit per stage, four lanes side by side) and one
// output register. The receiver cannot stall:
// done is a strobe and the word is gone after that cycle.
module disk_overlap_resolver
    import dor_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  dor_in_t  disks,
    output logic     done,
    output dor_out_t result
);

    // widths of the datapath
    localparam int SUMR_W = RADIUS_W + 1;               // sum of radii
    localparam int EXT_W  = (COORD_W + 1 > SUMR_W + 1) ? COORD_W + 1 : SUMR_W + 1;
    localparam int MAG_W  = SUMR_W;                     // |delta| after early reject
    localparam int RAD_W  = 2 * MAG_W;                  // squared length
    localparam int ROOT_W = MAG_W;                      // integer square root
    localparam int REM_S  = ROOT_W + 3;                 // root remainder
    localparam int GAP_W  = SUMR_W + 1;                 // signed overlap depth
    localparam int DEN_W  = MASS_W + 1;                 // mass sum
    localparam int DIV_W  = ROOT_W + DEN_W;             // len * den
    localparam int GW_W   = MAG_W + DEN_W;              // |gap| * weight
    localparam int N_W    = MAG_W + GW_W;               // full numerator
    localparam int CMP_A  = (N_W + 1 > DIV_W + COORD_W) ? N_W + 1 : DIV_W + COORD_W;
    localparam int CMP_W  = CMP_A + 1;
    localparam int LANES  = 4;                          // a_x, a_y, b_x, b_y

    localparam logic [ROOT_W-1:0]  ONE_LEN = ROOT_W'(1) << FRAC_BITS;
    localparam logic [MAG_W-1:0]   ONE_MAG = MAG_W'(1) << FRAC_BITS;
    localparam logic [COORD_W-1:0] LIM_POS = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] LIM_NEG = {1'b1, {(COORD_W-1){1'b0}}};

    // context that rides along with the square root
    typedef struct packed {
        logic              hit;
        logic [SUMR_W-1:0] sumr;
        logic              sx;
        logic              sy;
        logic [MAG_W-1:0]  mx;
        logic [MAG_W-1:0]  my;
        logic [DEN_W-1:0]  wa;
        logic [DEN_W-1:0]  wb;
        logic [DEN_W-1:0]  den;
    } ctx_t;

    typedef struct packed {
        ctx_t              ctx;
        logic              reject;
        logic [RAD_W-1:0]  sqx;
        logic [RAD_W-1:0]  sqy;
        logic [RAD_W-1:0]  sr2;
    } sq_in_t;

    typedef struct packed {
        ctx_t              ctx;
        logic [RAD_W-1:0]  rad;
        logic [REM_S-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } rt_t;

    typedef struct packed {
        logic              hit;
        logic              sx;
        logic              sy;
        logic              gneg;
        logic [MAG_W-1:0]  mx;
        logic [MAG_W-1:0]  my;
        logic [MAG_W-1:0]  gmag;
        logic [DEN_W-1:0]  wa;
        logic [DEN_W-1:0]  wb;
        logic [DIV_W-1:0]  div;
    } l1_t;

    typedef struct packed {
        logic              hit;
        logic              sx;
        logic              sy;
        logic              gneg;
        logic [MAG_W-1:0]  mx;
        logic [MAG_W-1:0]  my;
        logic [GW_W-1:0]   pa;
        logic [GW_W-1:0]   pb;
        logic [DIV_W-1:0]  div;
    } l2_t;

    typedef struct packed {
        logic                        hit;
        logic [LANES-1:0]            neg;
        logic [LANES-1:0][N_W-1:0]   num;
        logic [DIV_W-1:0]            div;
    } l3_t;

    typedef struct packed {
        logic                         hit;
        logic [LANES-1:0]             neg;
        logic [LANES-1:0]             sat;
        logic [LANES-1:0][CMP_W-1:0]  rem;
        logic [LANES-1:0][COORD_W-1:0] quo;
        logic [DIV_W-1:0]             div;
    } dv_t;

    // ------------------------------------------------------------------
    // stage 0: input register
    // ------------------------------------------------------------------
    logic    s0_vld_reg;
    dor_in_t s0_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
        end
        else
        begin
            s0_vld_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_reg <= disks;
    end

    // ------------------------------------------------------------------
    // stage 1: delta, early reject, mass ratio
    // ------------------------------------------------------------------
    logic signed [EXT_W-1:0] ax, ay, bx, by, dx, dy;
    logic [EXT_W-1:0]        adx, ady, sumr_ext;
    logic [SUMR_W-1:0]       sumr;
    logic [DEN_W-1:0]        num1, den1;
    logic                    reject1;
    ctx_t                    s1_next;
    logic                    s1_rej_next;

    always_comb
    begin
        ax = {{(EXT_W-COORD_W){s0_reg.pos_a_x[COORD_W-1]}}, s0_reg.pos_a_x};
        ay = {{(EXT_W-COORD_W){s0_reg.pos_a_y[COORD_W-1]}}, s0_reg.pos_a_y};
        bx = {{(EXT_W-COORD_W){s0_reg.pos_b_x[COORD_W-1]}}, s0_reg.pos_b_x};
        by = {{(EXT_W-COORD_W){s0_reg.pos_b_y[COORD_W-1]}}, s0_reg.pos_b_y};
        dx = bx - ax;
        dy = by - ay;
        adx = dx[EXT_W-1] ? EXT_W'(-dx) : EXT_W'(dx);
        ady = dy[EXT_W-1] ? EXT_W'(-dy) : EXT_W'(dy);
        sumr = {1'b0, s0_reg.radius_a} + {1'b0, s0_reg.radius_b};
        sumr_ext = {{(EXT_W-SUMR_W){1'b0}}, sumr};
        reject1 = (s0_reg.fixed_a && s0_reg.fixed_b) || (adx >= sumr_ext)
                  || (ady >= sumr_ext);

        // mass ratio num/den, fixed flags first
        priority if (s0_reg.fixed_a)
        begin
            num1 = DEN_W'(1);
            den1 = DEN_W'(1);
        end
        else if (s0_reg.fixed_b)
        begin
            num1 = '0;
            den1 = DEN_W'(1);
        end
        else if (s0_reg.mass_a == '0 && s0_reg.mass_b == '0)
        begin
            num1 = DEN_W'(1);
            den1 = DEN_W'(2);
        end
        else
        begin
            num1 = {1'b0, s0_reg.mass_a};
            den1 = {1'b0, s0_reg.mass_a} + {1'b0, s0_reg.mass_b};
        end

        s1_next.hit  = 1'b0;
        s1_next.sumr = sumr;
        s1_next.sx   = dx[EXT_W-1];
        s1_next.sy   = dy[EXT_W-1];
        s1_next.mx   = adx[MAG_W-1:0];
        s1_next.my   = ady[MAG_W-1:0];
        s1_next.wa   = den1 - num1;
        s1_next.wb   = num1;
        s1_next.den  = den1;
        s1_rej_next  = reject1;
    end

    logic s1_vld_reg;
    ctx_t s1_reg;
    logic s1_rej_reg;

    // ------------------------------------------------------------------
    // stage 2: squares
    // ------------------------------------------------------------------
    logic   s2_vld_reg;
    sq_in_t s2_reg;
    sq_in_t s2_next;

    always_comb
    begin
        s2_next.ctx    = s1_reg;
        s2_next.reject = s1_rej_reg;
        s2_next.sqx    = RAD_W'(s1_reg.mx * s1_reg.mx);
        s2_next.sqy    = RAD_W'(s1_reg.my * s1_reg.my);
        s2_next.sr2    = RAD_W'(s1_reg.sumr * s1_reg.sumr);
    end

    // ------------------------------------------------------------------
    // stage 3: squared length, overlap test, root seed
    // ------------------------------------------------------------------
    logic [RAD_W:0] d2;
    rt_t            rt_seed;

    always_comb
    begin
        d2 = {1'b0, s2_reg.sqx} + {1'b0, s2_reg.sqy};
        rt_seed.ctx     = s2_reg.ctx;
        rt_seed.ctx.hit = !s2_reg.reject && ({1'b0, s2_reg.sr2} > d2);
        rt_seed.rad     = d2[RAD_W-1:0];
        rt_seed.rem     = '0;
        rt_seed.root    = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= s0_vld_reg;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg     <= s1_next;
        s1_rej_reg <= s1_rej_next;
        s2_reg     <= s2_next;
    end

    // ------------------------------------------------------------------
    // square root: entry 0 is the seed register, one root bit per stage
    // ------------------------------------------------------------------
    logic [ROOT_W:0] rt_vld_reg;
    rt_t             rt_reg [ROOT_W+1];
    rt_t             rt_next [ROOT_W+1];

    assign rt_next[0] = rt_seed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rt_vld_reg <= '0;
        end
        else
        begin
            rt_vld_reg <= {rt_vld_reg[ROOT_W-1:0], s2_vld_reg};
        end
    end

    genvar k;
    generate
        for (k = 0; k < ROOT_W; k++)
        begin : g_root
            logic [REM_S-1:0] rin, trial;
            logic             ge;

            always_comb
            begin
                rin   = {rt_reg[k].rem[REM_S-3:0], rt_reg[k].rad[RAD_W-1 -: 2]};
                trial = {{(REM_S-ROOT_W-2){1'b0}}, rt_reg[k].root, 2'b01};
                ge    = rin >= trial;
                rt_next[k+1].ctx  = rt_reg[k].ctx;
                rt_next[k+1].rad  = {rt_reg[k].rad[RAD_W-3:0], 2'b00};
                rt_next[k+1].rem  = ge ? rin - trial : rin;
                rt_next[k+1].root = {rt_reg[k].root[ROOT_W-2:0], ge};
            end
        end

        for (k = 0; k <= ROOT_W; k++)
        begin : g_root_reg
            always_ff @(posedge clk)
            begin
                rt_reg[k] <= rt_next[k];
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // l1: coincident centres, overlap depth, divisor
    // ------------------------------------------------------------------
    rt_t                     rt_last;
    logic [ROOT_W-1:0]       len1;
    logic                    coinc;
    logic signed [GAP_W-1:0] gap;
    logic [GAP_W-1:0]        gabs;
    l1_t                     l1_next;
    l1_t                     l1_reg;
    logic                    l1_vld_reg;

    always_comb
    begin
        rt_last = rt_reg[ROOT_W];
        coinc   = rt_last.root == '0;
        len1    = coinc ? ONE_LEN : rt_last.root;
        gap     = {1'b0, rt_last.ctx.sumr} - {1'b0, len1};
        gabs    = gap[GAP_W-1] ? GAP_W'(-gap) : GAP_W'(gap);

        l1_next.hit  = rt_last.ctx.hit;
        l1_next.sx   = coinc ? 1'b0 : rt_last.ctx.sx;
        l1_next.sy   = coinc ? 1'b0 : rt_last.ctx.sy;
        l1_next.gneg = gap[GAP_W-1];
        l1_next.mx   = coinc ? ONE_MAG : rt_last.ctx.mx;
        l1_next.my   = coinc ? '0 : rt_last.ctx.my;
        l1_next.gmag = gabs[MAG_W-1:0];
        l1_next.wa   = rt_last.ctx.wa;
        l1_next.wb   = rt_last.ctx.wb;
        l1_next.div  = DIV_W'(len1 * rt_last.ctx.den);
    end

    // ------------------------------------------------------------------
    // l2: depth times weight per disk
    // ------------------------------------------------------------------
    l2_t  l2_next;
    l2_t  l2_reg;
    logic l2_vld_reg;

    always_comb
    begin
        l2_next.hit  = l1_reg.hit;
        l2_next.sx   = l1_reg.sx;
        l2_next.sy   = l1_reg.sy;
        l2_next.gneg = l1_reg.gneg;
        l2_next.mx   = l1_reg.mx;
        l2_next.my   = l1_reg.my;
        l2_next.pa   = GW_W'(l1_reg.gmag * l1_reg.wa);
        l2_next.pb   = GW_W'(l1_reg.gmag * l1_reg.wb);
        l2_next.div  = l1_reg.div;
    end

    // ------------------------------------------------------------------
    // l3: full numerators, lane order a_x, a_y, b_x, b_y
    // ------------------------------------------------------------------
    l3_t  l3_next;
    l3_t  l3_reg;
    logic l3_vld_reg;

    always_comb
    begin
        l3_next.hit    = l2_reg.hit;
        l3_next.div    = l2_reg.div;
        // disk a moves against delta
        l3_next.neg[0] = !l2_reg.sx ^ l2_reg.gneg;
        l3_next.neg[1] = !l2_reg.sy ^ l2_reg.gneg;
        l3_next.neg[2] = l2_reg.sx ^ l2_reg.gneg;
        l3_next.neg[3] = l2_reg.sy ^ l2_reg.gneg;
        l3_next.num[0] = N_W'(l2_reg.mx * l2_reg.pa);
        l3_next.num[1] = N_W'(l2_reg.my * l2_reg.pa);
        l3_next.num[2] = N_W'(l2_reg.mx * l2_reg.pb);
        l3_next.num[3] = N_W'(l2_reg.my * l2_reg.pb);
    end

    // ------------------------------------------------------------------
    // l4: rounding offset and saturation check, seeds the divider
    // ------------------------------------------------------------------
    dv_t              dv_seed;
    logic [CMP_W-1:0] div_top;

    always_comb
    begin
        div_top     = CMP_W'(l3_reg.div) << COORD_W;
        dv_seed.hit = l3_reg.hit;
        dv_seed.neg = l3_reg.neg;
        dv_seed.div = l3_reg.div;
        dv_seed.quo = '0;
        for (int i = 0; i < LANES; i++)
        begin
            dv_seed.rem[i] = CMP_W'(l3_reg.num[i]) + CMP_W'(l3_reg.div >> 1);
            dv_seed.sat[i] = dv_seed.rem[i] >= div_top;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l1_vld_reg <= 1'b0;
            l2_vld_reg <= 1'b0;
            l3_vld_reg <= 1'b0;
        end
        else
        begin
            l1_vld_reg <= rt_vld_reg[ROOT_W];
            l2_vld_reg <= l1_vld_reg;
            l3_vld_reg <= l2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        l1_reg <= l1_next;
        l2_reg <= l2_next;
        l3_reg <= l3_next;
    end

    // ------------------------------------------------------------------
    // restoring division: entry 0 is the seed, msb quotient bit first
    // ------------------------------------------------------------------
    logic [COORD_W:0] dv_vld_reg;
    dv_t              dv_reg [COORD_W+1];
    dv_t              dv_next [COORD_W+1];

    assign dv_next[0] = dv_seed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_vld_reg <= '0;
        end
        else
        begin
            dv_vld_reg <= {dv_vld_reg[COORD_W-1:0], l3_vld_reg};
        end
    end

    genvar j;
    generate
        for (j = 0; j < COORD_W; j++)
        begin : g_div
            localparam int SH = COORD_W - 1 - j;
            logic [CMP_W-1:0] dsh;
            logic             ge;

            always_comb
            begin
                dsh        = CMP_W'(dv_reg[j].div) << SH;
                dv_next[j+1] = dv_reg[j];
                for (int i = 0; i < LANES; i++)
                begin
                    ge = dv_reg[j].rem[i] >= dsh;
                    dv_next[j+1].rem[i]     = ge ? dv_reg[j].rem[i] - dsh
                                                 : dv_reg[j].rem[i];
                    dv_next[j+1].quo[i][SH] = ge;
                end
            end
        end

        for (j = 0; j <= COORD_W; j++)
        begin : g_div_reg
            always_ff @(posedge clk)
            begin
                dv_reg[j] <= dv_next[j];
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // output: sign, saturate, gate by hit
    // ------------------------------------------------------------------
    dv_t                            dv_last;
    logic [LANES-1:0][COORD_W-1:0]  mv;
    dor_out_t                       result_next;
    dor_out_t                       result_reg;
    logic                           done_reg;

    always_comb
    begin
        dv_last = dv_reg[COORD_W];
        for (int i = 0; i < LANES; i++)
        begin
            priority if (!dv_last.hit)
            begin
                mv[i] = '0;
            end
            else if (dv_last.neg[i])
            begin
                mv[i] = (dv_last.sat[i] || dv_last.quo[i] > LIM_NEG)
                        ? LIM_NEG : COORD_W'(-dv_last.quo[i]);
            end
            else
            begin
                mv[i] = (dv_last.sat[i] || dv_last.quo[i] > LIM_POS)
                        ? LIM_POS : dv_last.quo[i];
            end
        end
        result_next.hit      = dv_last.hit;
        result_next.move_a_x = mv[0];
        result_next.move_a_y = mv[1];
        result_next.move_b_x = mv[2];
        result_next.move_b_y = mv[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_vld_reg[COORD_W];
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
